// ===== rtl/core/bda_pkg.sv =====
// ============================================================================
// bda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ============================================================================
package bda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int MAX_DIGITS = 10;
    localparam int NDIG_W     = 4;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CONV_STEPS = VALUE_W;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // thresholds for the digit count: 10^1 .. 10^9
    localparam logic [VALUE_W-1:0] POW10 [0:MAX_DIGITS-2] = '{
        32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [NDIG_W-1:0]  ndig;
    } q_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } back_state_t;

endpackage

// ===== rtl/core/bda_front.sv =====
// ============================================================================
// bda_front
// Input stage: takes a word, counts its decimal digits, hands it to the queue.
// ============================================================================
module bda_front import bda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    input  q_status_t          q_status,
    output logic               q_push,
    output q_word_t            q_word
);

    logic               valid_reg;
    q_word_t            word_reg;
    logic [NDIG_W-1:0]  ndig;
    logic               accept;

    always_comb
    begin
        ndig = NDIG_W'(1);
        for (int k = 0; k < MAX_DIGITS - 1; k++)
        begin
            if (value >= POW10[k])
            begin
                ndig = ndig + NDIG_W'(1);
            end
        end
    end

    assign q_push   = valid_reg && !q_status.full;
    assign in_stall = valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign q_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.value <= value;
            word_reg.ndig  <= ndig;
        end
    end

endmodule

// ===== rtl/core/bda_fifo.sv =====
// ============================================================================
// bda_fifo
// Short queue between the front and back parts.
// ============================================================================
module bda_fifo import bda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_word_t   push_word,
    input  logic      pop,
    output q_word_t   pop_word,
    output q_status_t status
);

    q_word_t           mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_word     = mem_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/core/bda_back.sv =====
// ============================================================================
// bda_back
// Double-dabble conversion followed by a digit serializer with output register.
// ============================================================================
module bda_back import bda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_status_t         q_status,
    input  q_word_t           q_word,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last_digit
);

    back_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_adj;
    logic [STEP_W-1:0]  cnt_reg;
    logic [NDIG_W-1:0]  idx_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic               emit_go;
    logic               conv_step;
    logic               emit_load;
    logic [5:0]         bit_base;
    logic [3:0]         cur_digit;

    assign emit_go   = !out_valid_reg || !out_stall;
    assign bit_base  = {2'b00, idx_reg} << 2;
    assign cur_digit = bcd_reg[bit_base +: 4];

    always_comb
    begin
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                bcd_reg[4*d +: 4] + 4'd3 : bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == STEP_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go && idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        conv_step = 1'b0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_pop     = !q_status.empty;
            ST_CONV: conv_step = 1'b1;
            ST_EMIT: emit_load = emit_go;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                cnt_reg <= '0;
                idx_reg <= q_word.ndig - NDIG_W'(1);
            end
            else if (conv_step)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
            end
            else if (emit_load && idx_reg != '0)
            begin
                idx_reg <= idx_reg - NDIG_W'(1);
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bin_reg <= q_word.value;
            bcd_reg <= '0;
        end
        else if (conv_step)
        begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
        if (emit_load)
        begin
            char_reg <= ASCII_ZERO + {2'b00, cur_digit};
            last_reg <= (idx_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> idx_reg < NDIG_W'(MAX_DIGITS))
        else $error("digit index out of range");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load && idx_reg == '0 |=> out_valid_reg && last_reg)
        else $error("final digit not flagged");

    a_no_load_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !emit_load)
        else $error("output overwritten while stalled");

endmodule

// ===== rtl/core/binary_to_decimal_ascii_top.sv =====
// ============================================================================
// binary_to_decimal_ascii_top
// Converts 32-bit unsigned words to decimal ASCII digit streams.
// ============================================================================
// Each accepted 32-bit word produces one output word per decimal digit, most
// significant first, no leading zeros ('0' for zero), last_digit set on the
// final one. The front stage counts digits and feeds a two-entry queue; the
// back stage runs a double-dabble loop, one bit per cycle, then emits one
// digit per cycle while out_stall is low, through an output register. The
// queue and the front register let up to three further numbers be taken
// while one number occupies the back stage.
module binary_to_decimal_ascii_top import bda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last_digit
);

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    q_word_t   push_word;
    q_word_t   pop_word;

    bda_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_status (q_status),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    bda_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .pop       (q_pop),
        .pop_word  (pop_word),
        .status    (q_status)
    );

    bda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_word     (pop_word),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule
